### src/depth_first_graph_walk_unit_assert.svh
// Assertion macros for the graph walk unit.
`ifndef DEPTH_FIRST_GRAPH_WALK_UNIT_ASSERT_SVH
`define DEPTH_FIRST_GRAPH_WALK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define DFGW_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define DFGW_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define DFGW_ASSERT(name, prop, msg)
`define DFGW_ASSERT_IMP(name, ante, cons, msg)
`endif

`endif

### src/dfgw_pkg.sv
// Types, constants and helpers of the graph walk unit.
`default_nettype none
package dfgw_pkg;

	localparam int NUM_VERTICES = 64;
	localparam int ADJ_ENTRIES  = 256;

	localparam int VW  = 6;                           // vertex field width
	localparam int VIW = $clog2(NUM_VERTICES);        // vertex index width
	localparam int EW  = $clog2(ADJ_ENTRIES);         // pool index width
	localparam int PW  = $clog2(ADJ_ENTRIES + 1);     // pool pointer, holds the empty code
	localparam int DW  = $clog2(NUM_VERTICES + 1);    // stack depth
	localparam int SW  = $clog2(NUM_VERTICES);        // stack index

	localparam logic [PW-1:0] LIST_NONE = PW'(ADJ_ENTRIES);

	localparam int S_TDATA_W = ((2 * VW + 7) / 8) * 8;
	localparam int M_TDATA_W = ((VW + 7) / 8) * 8;

	localparam logic FUNC_EDGE = 1'b0;
	localparam logic FUNC_WALK = 1'b1;

	typedef enum logic [1:0] {
		KIND_VISIT  = 2'd0,
		KIND_STORED = 2'd1,
		KIND_DROP   = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_E_WR,
		ST_E_LNK,
		ST_E_NEXT,
		ST_RESP,
		ST_W_HEAD,
		ST_W_STEP,
		ST_W_ENT,
		ST_W_POP,
		ST_W_FIN
	} state_t;

	// per-vertex list row; the tail's target is kept so the link patch needs no read
	typedef struct packed {
		logic [VW-1:0] tail_tgt;
		logic [EW-1:0] tail;
		logic [EW-1:0] head;
	} ht_row_t;

	typedef struct packed {
		logic [PW-1:0] link;
		logic [VW-1:0] target;
	} entry_t;

	function automatic logic in_range(logic [VW-1:0] v);
		return 32'(v) < NUM_VERTICES;
	endfunction

	function automatic logic [VIW-1:0] vidx(logic [VW-1:0] v);
		return v[VIW-1:0];
	endfunction

endpackage
`default_nettype wire

### src/dfgw_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module dfgw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### src/depth_first_graph_walk_unit.sv
// Top level: adjacency-list graph store with depth-first walk.
//
// channel  dir  tdata                          tuser          tlast
// s_axis   in   vertex_a[5:0], vertex_b[11:6]  func           -
// m_axis   out  vertex[5:0]                    kind[1:0]      last
//
// Add edge: two appends through the list-row memory.
// Walk: a scan step and a pool read per list entry scanned; per newly visited vertex a head
// read, final scan step and stack pop, since each memory has a single read port.
// Reset clears list-empty and visited flags in flops; no clearing pass is needed.
// A stalled output holds the walk in place; the next request is taken while a
// finished result still waits.
`default_nettype none
`include "depth_first_graph_walk_unit_assert.svh"
module depth_first_graph_walk_unit
	import dfgw_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output      logic                 s_axis_tready,
	input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // vertex_a, vertex_b, zero pad
	input  wire logic                 s_axis_tuser,   // func
	output      logic                 m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output      logic [M_TDATA_W-1:0] m_axis_tdata,   // vertex, zero pad
	output      logic [1:0]           m_axis_tuser,   // kind
	output      logic                 m_axis_tlast
);

	state_t                  state_q, state_d;
	logic [PW-1:0]           used_q, used_d;
	logic [NUM_VERTICES-1:0] visited_q, visited_d;
	logic [NUM_VERTICES-1:0] nonempty_q, nonempty_d;
	logic [VW-1:0]           own_q, own_d, tgt_q, tgt_d;
	logic                    second_q, second_d;
	logic [EW-1:0]           tail_q, tail_d;
	logic [VW-1:0]           tail_tgt_q, tail_tgt_d;
	logic [DW-1:0]           depth_q, depth_d;
	logic [PW-1:0]           top_pos_q, top_pos_d;
	logic [VW-1:0]           cur_q, cur_d;
	logic [VW-1:0]           pend_q, pend_d;
	logic                    pend_v_q, pend_v_d;
	kind_t                   resp_kind_q, resp_kind_d;
	logic                    out_v_q, out_v_d;
	kind_t                   out_kind_q, out_kind_d;
	logic [VW-1:0]           out_vertex_q, out_vertex_d;
	logic                    out_last_q, out_last_d;

	logic                    ht_we, ht_re;
	logic [VIW-1:0]          ht_waddr, ht_raddr;
	ht_row_t                 ht_wdata, ht_rdata;
	logic                    en_we, en_re;
	logic [EW-1:0]           en_waddr, en_raddr;
	entry_t                  en_wdata, en_rdata;
	logic                    st_we, st_re;
	logic [SW-1:0]           st_waddr, st_raddr;
	logic [PW-1:0]           st_wdata, st_rdata;

	logic                       vr_we, vr_re;
	logic [VIW:0]               vr_waddr, vr_raddr;
	logic [$bits(ht_row_t)-1:0] vr_wdata, vr_rdata;

	logic [VW-1:0]           in_a, in_b;
	logic                    out_free;
	logic [DW-1:0]           pop_slot, push_slot;
	logic                    fresh;
	logic                    out_visit;

	dfgw_ram #(.WIDTH($bits(ht_row_t)), .DEPTH(2 * NUM_VERTICES)) u_vertex_ram (
		.clk(clk), .we(vr_we), .waddr(vr_waddr), .wdata(vr_wdata),
		.re(vr_re), .raddr(vr_raddr), .rdata(vr_rdata)
	);

	dfgw_ram #(.WIDTH($bits(entry_t)), .DEPTH(ADJ_ENTRIES)) u_entry_ram (
		.clk(clk), .we(en_we), .waddr(en_waddr), .wdata(en_wdata),
		.re(en_re), .raddr(en_raddr), .rdata(en_rdata)
	);

	// list rows in the lower half, stack slots in the upper half; never both in one cycle
	assign vr_we    = ht_we || st_we;
	assign vr_waddr = st_we ? {1'b1, st_waddr} : {1'b0, ht_waddr};
	assign vr_wdata = st_we ? {{($bits(ht_row_t) - PW){1'b0}}, st_wdata} : ht_wdata;
	assign vr_re    = ht_re || st_re;
	assign vr_raddr = st_re ? {1'b1, st_raddr} : {1'b0, ht_raddr};
	assign ht_rdata = vr_rdata;
	assign st_rdata = vr_rdata[PW-1:0];

	assign in_a      = s_axis_tdata[VW-1:0];
	assign in_b      = s_axis_tdata[2*VW-1:VW];
	assign out_free  = !out_v_q || m_axis_tready;
	assign pop_slot  = depth_q - DW'(2);
	assign push_slot = depth_q - DW'(1);
	assign fresh     = in_range(en_rdata.target) && !visited_q[vidx(en_rdata.target)];
	assign out_visit = out_v_q && out_kind_q == KIND_VISIT;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = M_TDATA_W'(out_vertex_q);
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	always_comb begin
		state_d      = state_q;
		used_d       = used_q;
		visited_d    = visited_q;
		nonempty_d   = nonempty_q;
		own_d        = own_q;
		tgt_d        = tgt_q;
		second_d     = second_q;
		tail_d       = tail_q;
		tail_tgt_d   = tail_tgt_q;
		depth_d      = depth_q;
		top_pos_d    = top_pos_q;
		cur_d        = cur_q;
		pend_d       = pend_q;
		pend_v_d     = pend_v_q;
		resp_kind_d  = resp_kind_q;
		out_v_d      = out_v_q && !m_axis_tready;
		out_kind_d   = out_kind_q;
		out_vertex_d = out_vertex_q;
		out_last_d   = out_last_q;

		ht_we    = 1'b0;
		ht_waddr = vidx(own_q);
		ht_wdata = '0;
		ht_re    = 1'b0;
		ht_raddr = vidx(in_a);
		en_we    = 1'b0;
		en_waddr = used_q[EW-1:0];
		en_wdata = '0;
		en_re    = 1'b0;
		en_raddr = top_pos_q[EW-1:0];
		st_we    = 1'b0;
		st_waddr = push_slot[SW-1:0];
		st_wdata = en_rdata.link;
		st_re    = 1'b0;
		st_raddr = pop_slot[SW-1:0];

		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					if (s_axis_tuser == FUNC_WALK) begin
						if (in_range(in_a)) begin
							visited_d[vidx(in_a)] = 1'b1;
							pend_d   = in_a;
							pend_v_d = 1'b1;
							cur_d    = in_a;
							depth_d  = '0;
							ht_re    = 1'b1;
							state_d  = ST_W_HEAD;
						end
					end else if (!in_range(in_a) || !in_range(in_b) ||
							32'(used_q) + 2 > ADJ_ENTRIES) begin
						resp_kind_d = KIND_DROP;
						state_d     = ST_RESP;
					end else begin
						own_d    = in_a;
						tgt_d    = in_b;
						second_d = 1'b0;
						ht_re    = 1'b1;
						state_d  = ST_E_WR;
					end
				end
			end
			ST_E_WR: begin
				en_we              = 1'b1;
				en_wdata.target    = tgt_q;
				en_wdata.link      = LIST_NONE;
				ht_we              = 1'b1;
				ht_wdata.tail_tgt  = tgt_q;
				ht_wdata.tail      = used_q[EW-1:0];
				ht_wdata.head      = nonempty_q[vidx(own_q)] ? ht_rdata.head : used_q[EW-1:0];
				nonempty_d[vidx(own_q)] = 1'b1;
				tail_d             = ht_rdata.tail;
				tail_tgt_d         = ht_rdata.tail_tgt;
				state_d            = nonempty_q[vidx(own_q)] ? ST_E_LNK : ST_E_NEXT;
			end
			ST_E_LNK: begin
				// patch the old tail to point at the new entry
				en_we           = 1'b1;
				en_waddr        = tail_q;
				en_wdata.target = tail_tgt_q;
				en_wdata.link   = used_q;
				state_d         = ST_E_NEXT;
			end
			ST_E_NEXT: begin
				used_d = used_q + PW'(1);
				if (!second_q) begin
					own_d    = tgt_q;
					tgt_d    = own_q;
					second_d = 1'b1;
					ht_re    = 1'b1;
					ht_raddr = vidx(tgt_q);
					state_d  = ST_E_WR;
				end else begin
					resp_kind_d = KIND_STORED;
					state_d     = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					out_v_d      = 1'b1;
					out_kind_d   = resp_kind_q;
					out_vertex_d = '0;
					out_last_d   = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_W_HEAD: begin
				top_pos_d = nonempty_q[vidx(cur_q)] ? PW'(ht_rdata.head) : LIST_NONE;
				depth_d   = depth_q + DW'(1);
				state_d   = ST_W_STEP;
			end
			ST_W_STEP: begin
				if (top_pos_q >= LIST_NONE) begin
					depth_d = depth_q - DW'(1);
					if (depth_q == DW'(1)) begin
						state_d = ST_W_FIN;
					end else begin
						st_re   = 1'b1;
						state_d = ST_W_POP;
					end
				end else begin
					en_re   = 1'b1;
					state_d = ST_W_ENT;
				end
			end
			ST_W_ENT: begin
				// read data holds while stalled: no new pool read is issued here
				if (!fresh) begin
					top_pos_d = en_rdata.link;
					state_d   = ST_W_STEP;
				end else if (out_free) begin
					top_pos_d    = en_rdata.link;
					visited_d[vidx(en_rdata.target)] = 1'b1;
					out_v_d      = 1'b1;
					out_kind_d   = KIND_VISIT;
					out_vertex_d = pend_q;
					out_last_d   = 1'b0;
					pend_d       = en_rdata.target;
					if (32'(depth_q) < NUM_VERTICES) begin
						st_we    = 1'b1;
						cur_d    = en_rdata.target;
						ht_re    = 1'b1;
						ht_raddr = vidx(en_rdata.target);
						state_d  = ST_W_HEAD;
					end else begin
						state_d  = ST_W_STEP;
					end
				end
			end
			ST_W_POP: begin
				top_pos_d = st_rdata;
				state_d   = ST_W_STEP;
			end
			ST_W_FIN: begin
				if (out_free) begin
					out_v_d      = 1'b1;
					out_kind_d   = KIND_VISIT;
					out_vertex_d = pend_q;
					out_last_d   = 1'b1;
					pend_v_d     = 1'b0;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			used_q     <= '0;
			visited_q  <= '0;
			nonempty_q <= '0;
			depth_q    <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			used_q     <= used_d;
			visited_q  <= visited_d;
			nonempty_q <= nonempty_d;
			depth_q    <= depth_d;
			pend_v_q   <= pend_v_d;
			out_v_q    <= out_v_d;
		end
	end

	always_ff @(posedge clk) begin
		own_q        <= own_d;
		tgt_q        <= tgt_d;
		second_q     <= second_d;
		tail_q       <= tail_d;
		tail_tgt_q   <= tail_tgt_d;
		top_pos_q    <= top_pos_d;
		cur_q        <= cur_d;
		pend_q       <= pend_d;
		resp_kind_q  <= resp_kind_d;
		out_kind_q   <= out_kind_d;
		out_vertex_q <= out_vertex_d;
		out_last_q   <= out_last_d;
	end

	`DFGW_ASSERT(a_depth_bound, 32'(depth_q) <= NUM_VERTICES, "walk stack overflow")
	`DFGW_ASSERT(a_pool_bound, 32'(used_q) <= ADJ_ENTRIES, "entry pool overrun")
	`DFGW_ASSERT_IMP(a_idle_flushed, state_q == ST_IDLE, !pend_v_q, "walk left a vertex unsent")
	`DFGW_ASSERT_IMP(a_visit_marked, out_visit, visited_q[vidx(out_vertex_q)], "vertex not marked")

endmodule
`default_nettype wire
